FILE: rtl/utr_pkg.sv
// Shared types, codes and constants of the update transfer receiver.
package utr_pkg;

   localparam logic [2:0] CMD_BEGIN  = 3'd0;
   localparam logic [2:0] CMD_CHUNK  = 3'd1;
   localparam logic [2:0] CMD_ABORT  = 3'd2;
   localparam logic [2:0] CMD_COMMIT = 3'd3;

   localparam logic [1:0] KIND_CREDIT = 2'd0;
   localparam logic [1:0] KIND_ACK    = 2'd1;
   localparam logic [1:0] KIND_NAK    = 2'd2;

   localparam logic [3:0] NAK_OK          = 4'd0;
   localparam logic [3:0] NAK_BAD_MSG     = 4'd1;
   localparam logic [3:0] NAK_UNCONFIRMED = 4'd2;
   localparam logic [3:0] NAK_LOW_BATTERY = 4'd3;
   localparam logic [3:0] NAK_TOO_LARGE   = 4'd4;
   localparam logic [3:0] NAK_BUSY        = 4'd5;
   localparam logic [3:0] NAK_NO_STORAGE  = 4'd6;
   localparam logic [3:0] NAK_YIELD       = 4'd7;
   localparam logic [3:0] NAK_HASH_FAIL   = 4'd8;

   localparam logic [1:0] REG_WINDOW  = 2'd0;
   localparam logic [1:0] REG_QUANTUM = 2'd1;
   localparam logic [1:0] REG_SLOT    = 2'd2;
   localparam logic [1:0] REG_MIN_BAT = 2'd3;

   localparam logic [15:0] RESET_WINDOW  = 16'd512;
   localparam logic [15:0] RESET_QUANTUM = 16'd512;
   localparam logic [31:0] RESET_SLOT    = 32'd262144;
   localparam logic [6:0]  RESET_MIN_BAT = 7'd30;

   localparam logic [15:0] BEGIN_MIN_LEN  = 16'd43;
   localparam logic [15:0] CHUNK_HDR_LEN  = 16'd7;
   localparam logic [15:0] COMMIT_MIN_LEN = 16'd3;
   localparam logic [7:0]  BATTERY_MAX    = 8'd100;

   localparam int MAX_REPLIES = 3;

   typedef struct packed {
      logic [15:0] window_bytes;
      logic [15:0] quantum_bytes;
      logic [31:0] slot_size;
      logic [6:0]  min_battery;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] msg_len;
      logic [15:0] xfer_id;
      logic [31:0] total_size;
      logic [31:0] chunk_offset;
      logic        image_trusted;
      logic [7:0]  batt_level;
      logic        on_charger;
      logic        erase_ok;
      logic        write_ok;
      logic        hash_match;
      logic        commit_accepted;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  code;
      logic [15:0] id;
      logic [31:0] offset;
      logic [15:0] credit;
      logic [31:0] fail;
      logic        touched;
   } reply_type;

   typedef struct packed {
      reply_type [MAX_REPLIES-1:0] rep;
      logic [1:0]                  count;
      logic [15:0]                 accepted;
   } bundle_type;

endpackage

FILE: rtl/utr_req_if.sv
// Request channel interface: one decoded message header with service outcomes.
interface utr_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [15:0] msg_len;
   logic [15:0] xfer_id;
   logic [31:0] total_size;
   logic [31:0] chunk_offset;
   logic        image_trusted;
   logic [7:0]  batt_level;
   logic        on_charger;
   logic        erase_ok;
   logic        write_ok;
   logic        hash_match;
   logic        commit_accepted;

   modport source (
      output valid, cmd, msg_len, xfer_id, total_size, chunk_offset, image_trusted,
             batt_level, on_charger, erase_ok, write_ok, hash_match, commit_accepted,
      input  ready
   );
   modport sink (
      input  valid, cmd, msg_len, xfer_id, total_size, chunk_offset, image_trusted,
             batt_level, on_charger, erase_ok, write_ok, hash_match, commit_accepted,
      output ready
   );
endinterface

FILE: rtl/utr_rsp_if.sv
// Response channel interface: one credit, ack or nak reply.
interface utr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  reply_kind;
   logic [3:0]  nak_code;
   logic [15:0] reply_id;
   logic [31:0] reply_offset;
   logic [15:0] reply_credit;
   logic [15:0] accepted_len;
   logic [31:0] fail_count;
   logic        was_touched;
   logic        last_of_run;

   modport source (
      output valid, reply_kind, nak_code, reply_id, reply_offset, reply_credit,
             accepted_len, fail_count, was_touched, last_of_run,
      input  ready
   );
   modport sink (
      input  valid, reply_kind, nak_code, reply_id, reply_offset, reply_credit,
             accepted_len, fail_count, was_touched, last_of_run,
      output ready
   );
endinterface

FILE: rtl/utr_csr.sv
// Configuration registers of the update transfer receiver.
module utr_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata,
   output utr_pkg::cfg_type cfg
);

   utr_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_bytes  <= utr_pkg::RESET_WINDOW;
         cfg_ff.quantum_bytes <= utr_pkg::RESET_QUANTUM;
         cfg_ff.slot_size     <= utr_pkg::RESET_SLOT;
         cfg_ff.min_battery   <= utr_pkg::RESET_MIN_BAT;
      end else if (csr_write) begin
         case (csr_index)
            utr_pkg::REG_WINDOW:  cfg_ff.window_bytes  <= csr_wdata[15:0];
            utr_pkg::REG_QUANTUM: cfg_ff.quantum_bytes <= csr_wdata[15:0];
            utr_pkg::REG_SLOT:    cfg_ff.slot_size     <= csr_wdata;
            utr_pkg::REG_MIN_BAT: cfg_ff.min_battery   <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/utr_core.sv
// Input register, transfer state and reply decision for one message header.
module utr_core (
   input  logic                clock,
   input  logic                reset,
   input  utr_pkg::cfg_type    cfg,
   input  logic                req_valid,
   input  utr_pkg::req_type    req_data,
   output logic                req_ready,
   input  logic                out_free,
   output logic                load,
   output utr_pkg::bundle_type bundle
);

   logic             in_vld_ff;
   utr_pkg::req_type in_ff;

   logic        active_ff,  active_in;
   logic [15:0] cur_id_ff,  cur_id_in;
   logic [31:0] total_ff,   total_in;
   logic [31:0] rcvd_ff,    rcvd_in;
   logic [15:0] credit_ff,  credit_in;
   logic [31:0] naks_ff,    naks_in;
   logic        touched_ff, touched_in;

   assign load      = in_vld_ff && out_free;
   assign req_ready = !in_vld_ff || out_free;

   always_comb begin
      logic [1:0]  kd [utr_pkg::MAX_REPLIES];
      logic [3:0]  cd [utr_pkg::MAX_REPLIES];
      logic [1:0]  n;
      logic [1:0]  run;
      logic        batt_ok;
      logic        begin_ok;
      logic        yield;
      logic [15:0] dl_raw;
      logic [15:0] dl;
      logic [32:0] sum;
      logic [15:0] accepted;
      logic        do_clear;

      for (int i = 0; i < utr_pkg::MAX_REPLIES; i++) begin
         kd[i] = utr_pkg::KIND_CREDIT;
         cd[i] = utr_pkg::NAK_OK;
      end
      n        = 2'd0;
      begin_ok = 1'b0;
      do_clear = 1'b0;
      accepted = 16'd0;

      active_in = active_ff;
      cur_id_in = cur_id_ff;
      total_in  = total_ff;
      rcvd_in   = rcvd_ff;
      credit_in = credit_ff;

      batt_ok = in_ff.on_charger || (in_ff.batt_level <= utr_pkg::BATTERY_MAX &&
                in_ff.batt_level >= {1'b0, cfg.min_battery});
      dl_raw  = in_ff.msg_len - utr_pkg::CHUNK_HDR_LEN;
      yield   = dl_raw > cfg.quantum_bytes;
      dl      = yield ? cfg.quantum_bytes : dl_raw;
      sum     = {1'b0, rcvd_ff} + {17'd0, dl};

      if (in_ff.msg_len != 16'd0) begin
         case (in_ff.cmd)
            utr_pkg::CMD_BEGIN: begin
               if (in_ff.msg_len < utr_pkg::BEGIN_MIN_LEN) begin
                  kd[0] = utr_pkg::KIND_NAK; cd[0] = utr_pkg::NAK_BAD_MSG; n = 2'd1;
               end else if (!in_ff.image_trusted) begin
                  kd[0] = utr_pkg::KIND_NAK; cd[0] = utr_pkg::NAK_UNCONFIRMED; n = 2'd1;
               end else if (!batt_ok) begin
                  kd[0] = utr_pkg::KIND_NAK; cd[0] = utr_pkg::NAK_LOW_BATTERY; n = 2'd1;
               end else if (in_ff.total_size == 32'd0 || in_ff.total_size > cfg.slot_size) begin
                  kd[0] = utr_pkg::KIND_NAK; cd[0] = utr_pkg::NAK_TOO_LARGE; n = 2'd1;
               end else if (active_ff && in_ff.xfer_id == cur_id_ff) begin
                  kd[0] = utr_pkg::KIND_ACK; kd[1] = utr_pkg::KIND_CREDIT; n = 2'd2;
               end else if (active_ff) begin
                  kd[0] = utr_pkg::KIND_NAK; cd[0] = utr_pkg::NAK_BUSY; n = 2'd1;
               end else if (!in_ff.erase_ok) begin
                  kd[0] = utr_pkg::KIND_NAK; cd[0] = utr_pkg::NAK_NO_STORAGE; n = 2'd1;
               end else begin
                  begin_ok  = 1'b1;
                  active_in = 1'b1;
                  cur_id_in = in_ff.xfer_id;
                  total_in  = in_ff.total_size;
                  rcvd_in   = 32'd0;
                  credit_in = cfg.window_bytes;
                  kd[0] = utr_pkg::KIND_CREDIT; kd[1] = utr_pkg::KIND_ACK; n = 2'd2;
               end
            end
            utr_pkg::CMD_CHUNK: begin
               if (!active_ff || in_ff.msg_len < utr_pkg::CHUNK_HDR_LEN ||
                   in_ff.xfer_id != cur_id_ff) begin
                  kd[0] = utr_pkg::KIND_NAK; cd[0] = utr_pkg::NAK_BAD_MSG; n = 2'd1;
               end else begin
                  if (yield) begin
                     kd[0] = utr_pkg::KIND_NAK; cd[0] = utr_pkg::NAK_YIELD; n = 2'd1;
                  end
                  if (in_ff.chunk_offset != rcvd_ff) begin
                     kd[n] = utr_pkg::KIND_ACK;
                     kd[n + 2'd1] = utr_pkg::KIND_CREDIT;
                     n = n + 2'd2;
                  end else if (sum > {1'b0, total_ff}) begin
                     kd[n] = utr_pkg::KIND_NAK; cd[n] = utr_pkg::NAK_BAD_MSG;
                     n = n + 2'd1;
                  end else if (dl > credit_ff) begin
                     kd[n] = utr_pkg::KIND_NAK; cd[n] = utr_pkg::NAK_BUSY;
                     kd[n + 2'd1] = utr_pkg::KIND_CREDIT;
                     n = n + 2'd2;
                  end else if (!in_ff.write_ok) begin
                     kd[n] = utr_pkg::KIND_NAK; cd[n] = utr_pkg::NAK_NO_STORAGE;
                     n = n + 2'd1;
                     do_clear = 1'b1;
                  end else begin
                     rcvd_in   = sum[31:0];
                     credit_in = cfg.window_bytes;
                     accepted  = dl;
                     kd[n] = utr_pkg::KIND_ACK;
                     kd[n + 2'd1] = utr_pkg::KIND_CREDIT;
                     n = n + 2'd2;
                  end
               end
            end
            utr_pkg::CMD_ABORT: begin
               do_clear = 1'b1;
               kd[0] = utr_pkg::KIND_CREDIT; n = 2'd1;
            end
            utr_pkg::CMD_COMMIT: begin
               if (!active_ff || in_ff.msg_len < utr_pkg::COMMIT_MIN_LEN ||
                   in_ff.xfer_id != cur_id_ff || rcvd_ff != total_ff) begin
                  kd[0] = utr_pkg::KIND_NAK; cd[0] = utr_pkg::NAK_BAD_MSG; n = 2'd1;
               end else if (!in_ff.hash_match) begin
                  kd[0] = utr_pkg::KIND_NAK; cd[0] = utr_pkg::NAK_HASH_FAIL; n = 2'd1;
                  do_clear = 1'b1;
               end else if (!in_ff.commit_accepted) begin
                  kd[0] = utr_pkg::KIND_NAK; cd[0] = utr_pkg::NAK_NO_STORAGE; n = 2'd1;
                  do_clear = 1'b1;
               end else begin
                  do_clear = 1'b1;
                  kd[0] = utr_pkg::KIND_CREDIT; n = 2'd1;
               end
            end
            default: begin
               kd[0] = utr_pkg::KIND_NAK; cd[0] = utr_pkg::NAK_BAD_MSG; n = 2'd1;
            end
         endcase
      end

      if (do_clear) begin
         active_in = 1'b0;
         cur_id_in = 16'd0;
         total_in  = 32'd0;
         rcvd_in   = 32'd0;
         credit_in = cfg.window_bytes;
      end

      run = 2'd0;
      for (int i = 0; i < utr_pkg::MAX_REPLIES; i++) begin
         if (2'(i) < n && kd[i] == utr_pkg::KIND_NAK) begin
            run = run + 2'd1;
         end
         bundle.rep[i].kind    = kd[i];
         bundle.rep[i].code    = cd[i];
         bundle.rep[i].id      = (kd[i] == utr_pkg::KIND_ACK) ? cur_id_in : 16'd0;
         bundle.rep[i].offset  = (kd[i] == utr_pkg::KIND_ACK) ? rcvd_in : 32'd0;
         bundle.rep[i].credit  = (kd[i] == utr_pkg::KIND_CREDIT) ? credit_in : 16'd0;
         bundle.rep[i].fail    = naks_ff + {30'd0, run};
         bundle.rep[i].touched = touched_ff || begin_ok || (run != 2'd0);
      end
      bundle.count    = n;
      bundle.accepted = accepted;

      naks_in    = naks_ff + {30'd0, run};
      touched_in = touched_ff || begin_ok || (run != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         active_ff  <= 1'b0;
         cur_id_ff  <= 16'd0;
         total_ff   <= 32'd0;
         rcvd_ff    <= 32'd0;
         credit_ff  <= utr_pkg::RESET_WINDOW;
         naks_ff    <= 32'd0;
         touched_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_vld_ff <= req_valid;
         end
         if (load) begin
            active_ff  <= active_in;
            cur_id_ff  <= cur_id_in;
            total_ff   <= total_in;
            rcvd_ff    <= rcvd_in;
            credit_ff  <= credit_in;
            naks_ff    <= naks_in;
            touched_ff <= touched_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_ff <= req_data;
      end
   end

`ifndef SYNTHESIS
   a_empty_msg_no_reply: assert property (@(posedge clock) disable iff (reset)
      load && in_ff.msg_len == 16'd0 |-> bundle.count == 2'd0)
      else $error("empty message produced replies");
   a_hold_until_load: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !load |=> in_vld_ff)
      else $error("pending item dropped");
   a_nak_count_step: assert property (@(posedge clock) disable iff (reset)
      load |=> naks_ff - $past(naks_ff) <= 32'd2)
      else $error("nak count jumped");
   a_accept_only_chunk: assert property (@(posedge clock) disable iff (reset)
      load && bundle.accepted != 16'd0 |-> in_ff.cmd == utr_pkg::CMD_CHUNK)
      else $error("bytes accepted outside a chunk");
`endif

endmodule

FILE: rtl/utr_out.sv
// Reply buffer that sends the replies of one item one per cycle while rsp_ready is high.
module utr_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  utr_pkg::bundle_type bundle,
   output logic                out_free,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output utr_pkg::reply_type  rsp_reply,
   output logic [15:0]         rsp_accepted,
   output logic                rsp_last
);

   utr_pkg::reply_type [utr_pkg::MAX_REPLIES-1:0] rep_ff;
   logic [15:0] acc_ff;
   logic [1:0]  cnt_ff;
   logic [1:0]  pos_ff;

   assign rsp_valid    = cnt_ff != 2'd0;
   assign rsp_last     = (pos_ff + 2'd1) == cnt_ff;
   assign rsp_reply    = rep_ff[pos_ff];
   assign rsp_accepted = acc_ff;
   assign out_free     = !rsp_valid || (rsp_ready && rsp_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         pos_ff <= 2'd0;
      end else if (load) begin
         cnt_ff <= bundle.count;
         pos_ff <= 2'd0;
      end else if (rsp_valid && rsp_ready) begin
         if (rsp_last) begin
            cnt_ff <= 2'd0;
            pos_ff <= 2'd0;
         end else begin
            pos_ff <= pos_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rep_ff <= bundle.rep;
         acc_ff <= bundle.accepted;
      end
   end

`ifndef SYNTHESIS
   a_pos_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pos_ff < cnt_ff)
      else $error("reply index beyond run");
   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last && !load |=> !rsp_valid)
      else $error("run did not end after its last reply");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> out_free)
      else $error("replies overwritten before delivery");
`endif

endmodule

FILE: rtl/update_transfer_receiver.sv
// Top level of the update transfer receiver.
//
// Usage: req_ch carries one decoded message header per item together with the
// outcomes of the trust, battery, erase, write, hash and commit services.
// rsp_ch returns zero to three replies (credit, ack or nak) per item, one per
// cycle while rsp_ch.ready is high, in order; last_of_run marks the final
// reply of an item. An item with msg_len zero gives no reply. Configuration
// registers are written through csr_write, csr_index and csr_wdata while the
// block is idle. An accepted item sits in the input register until the
// reply buffer is free, then moves into the reply buffer, which drives its
// first reply. Each item holds the reply buffer until its last reply is taken,
// and the next item is loaded as that last reply is accepted; items with no
// reply pass at one item per cycle.
// A new item is taken into the input register while replies are still out.
// Reset (synchronous, active high) clears the transfer, nak count and touched
// flag and loads the configuration defaults. When rsp_ch stalls, the current
// reply holds, the input register fills, and then req_ch.ready drops.
module update_transfer_receiver (
   input  logic        clock,
   input  logic        reset,
   utr_req_if.sink     req_ch,
   utr_rsp_if.source   rsp_ch,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   utr_pkg::cfg_type    cfg;
   utr_pkg::req_type    req_data;
   utr_pkg::bundle_type bundle;
   utr_pkg::reply_type  rsp_reply;
   logic                out_free;
   logic                load;
   logic                req_ready;
   logic                rsp_valid;
   logic [15:0]         rsp_accepted;
   logic                rsp_last;

   assign req_data.cmd             = req_ch.cmd;
   assign req_data.msg_len         = req_ch.msg_len;
   assign req_data.xfer_id         = req_ch.xfer_id;
   assign req_data.total_size      = req_ch.total_size;
   assign req_data.chunk_offset    = req_ch.chunk_offset;
   assign req_data.image_trusted   = req_ch.image_trusted;
   assign req_data.batt_level      = req_ch.batt_level;
   assign req_data.on_charger      = req_ch.on_charger;
   assign req_data.erase_ok        = req_ch.erase_ok;
   assign req_data.write_ok        = req_ch.write_ok;
   assign req_data.hash_match      = req_ch.hash_match;
   assign req_data.commit_accepted = req_ch.commit_accepted;
   assign req_ch.ready             = req_ready;

   utr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   utr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_ch.valid),
      .req_data  (req_data),
      .req_ready (req_ready),
      .out_free  (out_free),
      .load      (load),
      .bundle    (bundle)
   );

   utr_out u_out (
      .clock        (clock),
      .reset        (reset),
      .load         (load),
      .bundle       (bundle),
      .out_free     (out_free),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ch.ready),
      .rsp_reply    (rsp_reply),
      .rsp_accepted (rsp_accepted),
      .rsp_last     (rsp_last)
   );

   assign rsp_ch.valid        = rsp_valid;
   assign rsp_ch.reply_kind   = rsp_reply.kind;
   assign rsp_ch.nak_code     = rsp_reply.code;
   assign rsp_ch.reply_id     = rsp_reply.id;
   assign rsp_ch.reply_offset = rsp_reply.offset;
   assign rsp_ch.reply_credit = rsp_reply.credit;
   assign rsp_ch.accepted_len = rsp_accepted;
   assign rsp_ch.fail_count   = rsp_reply.fail;
   assign rsp_ch.was_touched  = rsp_reply.touched;
   assign rsp_ch.last_of_run  = rsp_last;

endmodule
